[src/fibre_conductivity_tensor_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fibre conductivity tensor core
// Concurrent checks, clocked on clk and disabled during reset; empty when
// the code is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef FIBRE_CONDUCTIVITY_TENSOR_CORE_MACROS_SVH
`define FIBRE_CONDUCTIVITY_TENSOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define FCT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fct: invariant violated");
// Condition that, when seen, must be followed by another in the next cycle.
`define FCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fct: sequence violated");
`else
`define FCT_ASSERT(name, prop)
`define FCT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[src/fct_pkg.sv]
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, constants and arithmetic helpers of the conductivity tensor.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int SIGMA_W        = 24;
  localparam int OUT_W          = 25;
  localparam int TRIG_W         = 16;
  localparam int MAG_W          = TRIG_W - 1;

  localparam int BACK_LATENCY   = 5;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 8;
  localparam int MID_CNT_W      = $clog2(MID_DEPTH + 1);
  localparam int OUT_CNT_W      = $clog2(OUT_DEPTH + 1);
  localparam int FLIGHT_W       = $clog2(BACK_LATENCY + 1);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [0:0] {
    REG_SIGMA_LONG  = 1'b0,
    REG_SIGMA_TRANS = 1'b1
  } cfg_reg_t;

  typedef logic [SIGMA_W-1:0]        sigma_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic signed [OUT_W-1:0]   tensor_t;

  typedef struct packed {
    trig_t sin_theta;
    trig_t cos_theta;
    trig_t sin_phi;
    trig_t cos_phi;
  } trig_set_t;

  typedef struct packed {
    tensor_t xx;
    tensor_t yy;
    tensor_t zz;
    tensor_t xy;
    tensor_t xz;
    tensor_t yz;
  } tensor_set_t;

  // Signed Q1.15 value from a table magnitude and a quadrant sign.
  function automatic trig_t apply_sign(input logic [MAG_W-1:0] mag, input logic neg);
    trig_t v;
    v = signed'({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // Product narrowed by an arithmetic right shift of 15, which is a floor.
  function automatic logic signed [26:0] mq(input logic signed [25:0] a,
                                             input logic signed [16:0] b);
    logic signed [42:0] p;
    p = a * b;
    return p[41:15];
  endfunction

  // Clamp to the signed Q8.16 result range.
  function automatic tensor_t sat(input logic signed [26:0] v);
    tensor_t r;
    if (v > 27'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (v < 27'(OUT_MIN)) begin
      r = OUT_MIN;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/fct_queue.sv]
// ----------------------------------------------------------------------------
// fct_queue
// Small first-in first-out queue with the oldest entry shown on rdata.
// ----------------------------------------------------------------------------
module fct_queue import fct_pkg::*; #(
  parameter int WIDTH = OUT_W,
  parameter int DEPTH = OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign rdata = entries[rd_ptr];
  assign empty = (count == '0);

endmodule

[src/fct_front.sv]
// ----------------------------------------------------------------------------
// fct_front
// Folds both angles onto a quarter wave and reads sine and cosine from ROM.
// ----------------------------------------------------------------------------
module fct_front import fct_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [ANGLE_BITS-1:0] theta,
  input  logic [ANGLE_BITS-1:0] phi,
  output logic                  out_valid,
  output trig_set_t             trig
);

  localparam int  QW         = ANGLE_BITS - 2;
  localparam int  QUARTER    = 1 << QW;
  localparam int  AW         = QW + 1;
  localparam real TWO_PI     = 6.283185307179586;
  localparam real ANGLE_STEP = TWO_PI / real'(4 * QUARTER);

  typedef logic [MAG_W-1:0] rom_t [QUARTER+1];

  // Quarter wave of round(32767 * sin), computed when the design is built.
  function automatic rom_t build_rom();
    rom_t r;
    real  x;
    for (int i = 0; i <= QUARTER; i++) begin
      x    = ANGLE_STEP * real'(i);
      r[i] = MAG_W'($rtoi(32767.0 * $sin(x) + 0.5));
    end
    return r;
  endfunction

  localparam rom_t THETA_ROM = build_rom();
  localparam rom_t PHI_ROM   = build_rom();

  logic [1:0]    th_quad, ph_quad;
  logic [AW-1:0] th_up, th_dn, ph_up, ph_dn;
  logic [AW-1:0] th_sin_addr, th_cos_addr, ph_sin_addr, ph_cos_addr;

  logic [MAG_W-1:0] th_sin_mag, th_cos_mag, ph_sin_mag, ph_cos_mag;
  logic             th_sin_neg, th_cos_neg, ph_sin_neg, ph_cos_neg;

  assign th_quad = theta[ANGLE_BITS-1 -: 2];
  assign ph_quad = phi[ANGLE_BITS-1 -: 2];
  assign th_up   = {1'b0, theta[QW-1:0]};
  assign ph_up   = {1'b0, phi[QW-1:0]};
  assign th_dn   = AW'(QUARTER) - th_up;
  assign ph_dn   = AW'(QUARTER) - ph_up;

  // Odd quadrants mirror the quarter wave; cosine sits one quadrant ahead.
  assign th_sin_addr = th_quad[0] ? th_dn : th_up;
  assign th_cos_addr = th_quad[0] ? th_up : th_dn;
  assign ph_sin_addr = ph_quad[0] ? ph_dn : ph_up;
  assign ph_cos_addr = ph_quad[0] ? ph_up : ph_dn;

  always_ff @(posedge clk) begin
    th_sin_mag <= THETA_ROM[th_sin_addr];
    th_cos_mag <= THETA_ROM[th_cos_addr];
    ph_sin_mag <= PHI_ROM[ph_sin_addr];
    ph_cos_mag <= PHI_ROM[ph_cos_addr];
    th_sin_neg <= th_quad[1];
    th_cos_neg <= th_quad[1] ^ th_quad[0];
    ph_sin_neg <= ph_quad[1];
    ph_cos_neg <= ph_quad[1] ^ ph_quad[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  assign trig.sin_theta = apply_sign(th_sin_mag, th_sin_neg);
  assign trig.cos_theta = apply_sign(th_cos_mag, th_cos_neg);
  assign trig.sin_phi   = apply_sign(ph_sin_mag, ph_sin_neg);
  assign trig.cos_phi   = apply_sign(ph_cos_mag, ph_cos_neg);

endmodule

[src/fct_back.sv]
// ----------------------------------------------------------------------------
// fct_back
// Five-stage multiply pipeline that forms the six tensor entries.
// ----------------------------------------------------------------------------
module fct_back import fct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  trig_set_t   trig,
  input  sigma_t      sigma_long,
  input  sigma_t      sigma_trans,
  output logic        out_valid,
  output tensor_set_t result
);

  logic [BACK_LATENCY-1:0] valid;

  tensor_t sl_in, st_in, d_in;

  // Stage 1
  logic signed [26:0] p1_sp2, p1_cp2, p1_st2, p1_ct2, p1_m1, p1_m2, p1_m3;
  trig_t   s1_sp2, s1_cp2, s1_st2, s1_ct2, s1_sth, s1_cth, s1_sp, s1_cp;
  tensor_t s1_m1, s1_m2, s1_m3, s1_sl, s1_st;

  // Stage 2
  logic signed [26:0] p2_cs, p2_ss, p2_cc, p2_sc, p2_zl, p2_zt, p2_a1, p2_b1, p2_c1;
  trig_t   s2_cs, s2_ss, s2_cc, s2_sc, s2_sp2, s2_cp2, s2_sp, s2_sth;
  tensor_t s2_zl, s2_zt, s2_a1, s2_b1, s2_c1, s2_sl, s2_st;

  // Stage 3
  logic signed [26:0] p3_a2, p3_b2, p3_c2;
  logic signed [16:0] s3_ta, s3_tb;
  trig_t   s3_cs, s3_ss;
  tensor_t s3_zz, s3_a2, s3_b2, s3_c2, s3_sl, s3_st;

  // Stage 4
  logic signed [26:0] p4_xl, p4_xt, p4_yl, p4_yt;
  tensor_t            s4_xl, s4_yl, s4_zz, s4_a2, s4_b2, s4_c2;
  logic signed [25:0] s4_xt, s4_yt;

  assign sl_in = signed'({1'b0, sigma_long});
  assign st_in = signed'({1'b0, sigma_trans});
  assign d_in  = sl_in - st_in;

  assign p1_sp2 = mq(26'(trig.sin_phi),   17'(trig.sin_phi));
  assign p1_cp2 = mq(26'(trig.cos_phi),   17'(trig.cos_phi));
  assign p1_st2 = mq(26'(trig.sin_theta), 17'(trig.sin_theta));
  assign p1_ct2 = mq(26'(trig.cos_theta), 17'(trig.cos_theta));
  assign p1_m1  = mq(26'(d_in), 17'(trig.cos_phi));
  assign p1_m2  = mq(26'(d_in), 17'(trig.cos_theta));
  assign p1_m3  = mq(26'(d_in), 17'(trig.sin_phi));

  always_ff @(posedge clk) begin
    s1_sp2 <= p1_sp2[TRIG_W-1:0];
    s1_cp2 <= p1_cp2[TRIG_W-1:0];
    s1_st2 <= p1_st2[TRIG_W-1:0];
    s1_ct2 <= p1_ct2[TRIG_W-1:0];
    s1_m1  <= p1_m1[OUT_W-1:0];
    s1_m2  <= p1_m2[OUT_W-1:0];
    s1_m3  <= p1_m3[OUT_W-1:0];
    s1_sth <= trig.sin_theta;
    s1_cth <= trig.cos_theta;
    s1_sp  <= trig.sin_phi;
    s1_cp  <= trig.cos_phi;
    s1_sl  <= sl_in;
    s1_st  <= st_in;
  end

  assign p2_cs = mq(26'(s1_cp2), 17'(s1_st2));
  assign p2_ss = mq(26'(s1_sp2), 17'(s1_st2));
  assign p2_cc = mq(26'(s1_cp2), 17'(s1_ct2));
  assign p2_sc = mq(26'(s1_sp2), 17'(s1_ct2));
  assign p2_zl = mq(26'(s1_sl),  17'(s1_ct2));
  assign p2_zt = mq(26'(s1_st),  17'(s1_st2));
  assign p2_a1 = mq(26'(s1_m1),  17'(s1_st2));
  assign p2_b1 = mq(26'(s1_m2),  17'(s1_cp));
  assign p2_c1 = mq(26'(s1_m3),  17'(s1_cth));

  always_ff @(posedge clk) begin
    s2_cs  <= p2_cs[TRIG_W-1:0];
    s2_ss  <= p2_ss[TRIG_W-1:0];
    s2_cc  <= p2_cc[TRIG_W-1:0];
    s2_sc  <= p2_sc[TRIG_W-1:0];
    s2_zl  <= p2_zl[OUT_W-1:0];
    s2_zt  <= p2_zt[OUT_W-1:0];
    s2_a1  <= p2_a1[OUT_W-1:0];
    s2_b1  <= p2_b1[OUT_W-1:0];
    s2_c1  <= p2_c1[OUT_W-1:0];
    s2_sp2 <= s1_sp2;
    s2_cp2 <= s1_cp2;
    s2_sp  <= s1_sp;
    s2_sth <= s1_sth;
    s2_sl  <= s1_sl;
    s2_st  <= s1_st;
  end

  assign p3_a2 = mq(26'(s2_a1), 17'(s2_sp));
  assign p3_b2 = mq(26'(s2_b1), 17'(s2_sth));
  assign p3_c2 = mq(26'(s2_c1), 17'(s2_sth));

  always_ff @(posedge clk) begin
    s3_ta <= 17'(s2_cc) + 17'(s2_sp2);
    s3_tb <= 17'(s2_cp2) + 17'(s2_sc);
    s3_zz <= sat(27'(s2_zl) + 27'(s2_zt));
    s3_a2 <= p3_a2[OUT_W-1:0];
    s3_b2 <= p3_b2[OUT_W-1:0];
    s3_c2 <= p3_c2[OUT_W-1:0];
    s3_cs <= s2_cs;
    s3_ss <= s2_ss;
    s3_sl <= s2_sl;
    s3_st <= s2_st;
  end

  assign p4_xl = mq(26'(s3_sl), 17'(s3_cs));
  assign p4_xt = mq(26'(s3_st), s3_ta);
  assign p4_yl = mq(26'(s3_sl), 17'(s3_ss));
  assign p4_yt = mq(26'(s3_st), s3_tb);

  // Off-diagonal products stay inside the result range, so they pass as is.
  always_ff @(posedge clk) begin
    s4_xl <= p4_xl[OUT_W-1:0];
    s4_xt <= p4_xt[25:0];
    s4_yl <= p4_yl[OUT_W-1:0];
    s4_yt <= p4_yt[25:0];
    s4_zz <= s3_zz;
    s4_a2 <= s3_a2;
    s4_b2 <= s3_b2;
    s4_c2 <= s3_c2;
  end

  always_ff @(posedge clk) begin
    result.xx <= sat(27'(s4_xl) + 27'(s4_xt));
    result.yy <= sat(27'(s4_yl) + 27'(s4_yt));
    result.zz <= s4_zz;
    result.xy <= s4_a2;
    result.xz <= s4_b2;
    result.yz <= s4_c2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[BACK_LATENCY-2:0], in_valid};
    end
  end

  assign out_valid = valid[BACK_LATENCY-1];

endmodule

[src/fibre_conductivity_tensor_core.sv]
// ----------------------------------------------------------------------------
// fibre_conductivity_tensor_core
// Transversely isotropic conductivity tensor from a fibre direction.
// ----------------------------------------------------------------------------
// Each accepted pair of angles (theta_angle, phi_angle), both fractions of a
// full turn, yields one result: the six distinct entries of the symmetric
// tensor sigma_trans*I + (sigma_long - sigma_trans)*f*f^T in signed Q8.16,
// saturated to 25 bits. The block sustains one transfer per clock cycle on
// both sides while full and empty are low. An item passes through the sine
// table lookup register, the queue between the lookup front and the
// arithmetic back, and five arithmetic stages before it enters the result
// queue, whose head drives the result ports. The back end's depth is set by
// its longest chain, on the xx and yy diagonal entries: a square, a product
// of squares, a sum, a product with a conductivity and a saturating add. The
// sigma registers are written through cfg_we, cfg_index and cfg_data and
// must only change while no item is in flight.
// ----------------------------------------------------------------------------
`include "fibre_conductivity_tensor_core_macros.svh"

module fibre_conductivity_tensor_core import fct_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [SIGMA_W-1:0]    cfg_data,
  // Input queue side
  input  logic                  push,
  output logic                  full,
  input  logic [ANGLE_BITS-1:0] theta_angle,
  input  logic [ANGLE_BITS-1:0] phi_angle,
  // Result queue side
  output logic                  empty,
  input  logic                  pop,
  output logic signed [OUT_W-1:0] diag_xx,
  output logic signed [OUT_W-1:0] diag_yy,
  output logic signed [OUT_W-1:0] diag_zz,
  output logic signed [OUT_W-1:0] off_xy,
  output logic signed [OUT_W-1:0] off_xz,
  output logic signed [OUT_W-1:0] off_yz
);

  sigma_t sigma_long;
  sigma_t sigma_trans;

  logic                 in_take;
  logic                 front_valid;
  trig_set_t            front_trig;

  logic [$bits(trig_set_t)-1:0] mid_rdata;
  logic                 mid_empty;
  logic [MID_CNT_W-1:0] mid_count;
  logic [MID_CNT_W:0]   mid_used;
  logic                 issue;

  logic                 back_valid;
  tensor_set_t          back_result;

  logic [$bits(tensor_set_t)-1:0] out_rdata;
  tensor_set_t          out_item;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_empty;
  logic                 out_take;

  logic [FLIGHT_W-1:0]  in_flight;
  logic [OUT_CNT_W:0]   credit_used;

  // Register file. Both indexes name a register, so every write lands.
  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_long  <= '0;
      sigma_trans <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SIGMA_LONG:  sigma_long  <= cfg_data;
        REG_SIGMA_TRANS: sigma_trans <= cfg_data;
        default:         sigma_long  <= sigma_long;
      endcase
    end
  end

  // The front holds one item in its lookup register before it lands in the
  // middle queue, so that item counts against the queue's room. This keeps
  // the queue from ever overflowing while still taking a transfer per cycle.
  assign mid_used = {1'b0, mid_count} + (MID_CNT_W + 1)'(front_valid);
  assign full     = (mid_used >= (MID_CNT_W + 1)'(MID_DEPTH));
  assign in_take  = push && !full;

  fct_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_take),
    .theta     (theta_angle),
    .phi       (phi_angle),
    .out_valid (front_valid),
    .trig      (front_trig)
  );

  fct_queue #(
    .WIDTH ($bits(trig_set_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_trig),
    .pop   (issue),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  // The back pipeline never stalls. An item is issued into it only when the
  // result queue is sure to have a slot for it, counting the results already
  // waiting there and those still moving through the multiply stages.
  assign credit_used = {1'b0, out_count} + (OUT_CNT_W + 1)'(in_flight);
  assign issue       = !mid_empty && (credit_used < (OUT_CNT_W + 1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      case ({issue, back_valid})
        2'b10:   in_flight <= in_flight + FLIGHT_W'(1);
        2'b01:   in_flight <= in_flight - FLIGHT_W'(1);
        default: in_flight <= in_flight;
      endcase
    end
  end

  fct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (issue),
    .trig        (trig_set_t'(mid_rdata)),
    .sigma_long  (sigma_long),
    .sigma_trans (sigma_trans),
    .out_valid   (back_valid),
    .result      (back_result)
  );

  // Result queue: its head drives the result ports directly.
  assign out_take = pop && !out_empty;

  fct_queue #(
    .WIDTH ($bits(tensor_set_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid),
    .wdata (back_result),
    .pop   (out_take),
    .rdata (out_rdata),
    .empty (out_empty),
    .count (out_count)
  );

  assign out_item = tensor_set_t'(out_rdata);
  assign empty    = out_empty;
  assign diag_xx  = out_item.xx;
  assign diag_yy  = out_item.yy;
  assign diag_zz  = out_item.zz;
  assign off_xy   = out_item.xy;
  assign off_xz   = out_item.xz;
  assign off_yz   = out_item.yz;

  // The middle queue is never written while it holds its full depth.
  `FCT_ASSERT(a_mid_no_overflow, !(front_valid && (mid_count == MID_CNT_W'(MID_DEPTH))))
  // Waiting plus in-flight results never exceed the result queue's depth.
  `FCT_ASSERT(a_out_credit, credit_used <= (OUT_CNT_W + 1)'(OUT_DEPTH))
  // A result leaving the back pipeline was issued earlier and is counted.
  `FCT_ASSERT(a_back_counted, !back_valid || (in_flight != '0))
  // An issued item is in flight on the next cycle.
  `FCT_ASSERT_NEXT(a_issue_tracked, issue, in_flight != '0)

endmodule
